[design/multi_pattern_byte_matcher_defines.svh]
// Assertion macros used by the matcher's RTL.
`ifndef MULTI_PATTERN_BYTE_MATCHER_DEFINES_SVH
`define MULTI_PATTERN_BYTE_MATCHER_DEFINES_SVH

// Same-cycle implication, sampled on clock and masked during reset.
`define MPBM_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("matcher check failed");

// Next-cycle implication, sampled on clock and masked during reset.
`define MPBM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("matcher check failed");

`endif

[design/mpbm_pkg.sv]
// Types, codes and sizes shared by the multi-pattern byte matcher files.
package mpbm_pkg;

   // Slots in the search and in the register file
   localparam int SLOT_COUNT        = 4;
   localparam int MAX_PATTERN_BYTES = 8;
   localparam int HW_SLOTS          = 4;
   localparam int NUM_SLOTS         = (SLOT_COUNT < HW_SLOTS) ? SLOT_COUNT : HW_SLOTS;

   // Field widths
   localparam int ACTION_W   = 2;
   localparam int BYTE_W     = 8;
   localparam int STATUS_W   = 2;
   localparam int SLOT_ID_W  = 3;
   localparam int POS_W      = 4;
   localparam int TICK_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   typedef logic [POS_W-1:0]                pos_type;
   typedef logic [7:0][BYTE_W-1:0]          pattern_type;

   // Action codes
   localparam logic [ACTION_W-1:0] ACT_START = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_BYTE  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_SEARCHING = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_TIMEOUT   = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_A   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_B   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_C   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_D   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LENGTHS     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SLOTS_INUSE = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT     = 3'd6;

   // Register reset values
   localparam logic [2:0]        SLOTS_RESET   = 3'd1;
   localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd1000;

endpackage

[design/mpbm_req_if.sv]
// Input channel: one word carries an action and a received byte.
interface mpbm_req_if;
   import mpbm_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [BYTE_W-1:0]   rx_byte;

   modport source (output valid, output action, output rx_byte, input ready);
   modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

[design/mpbm_rsp_if.sv]
// Result channel: one word carries the search status and matched slot.
interface mpbm_rsp_if;
   import mpbm_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [SLOT_ID_W-1:0] matched_slot;

   modport source (output valid, output status, output matched_slot, input ready);
   modport sink   (input valid, input status, input matched_slot, output ready);
endinterface

[design/mpbm_csr_if.sv]
// Configuration write channel: register index and write data.
interface mpbm_csr_if;
   import mpbm_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[design/multi_pattern_byte_matcher.sv]
// Multi-pattern byte matcher with tick timeout: the whole block in one module.
//
// The matcher takes one word per clock on req (start, received byte or timer
// tick) and returns exactly one result word on rsp for each. Each word passes
// through an input register, where all pattern slots are compared against it
// in parallel, and the status then lands in the result register once that
// register is free.
// Throughput is one word per cycle, held only by rsp backpressure; a waiting
// result still lets one word into an empty input register, and input stalls
// only while both registers are full. Patterns, lengths, slot count and timeout
// are written through csr, which is always ready; write them only while no word
// is in flight. A search ends on a found pattern or on timeout, and the final
// status is repeated for every later word until the next start.
`include "multi_pattern_byte_matcher_defines.svh"

module multi_pattern_byte_matcher (
   input logic         clock,
   input logic         reset,
   mpbm_req_if.sink    req,
   mpbm_rsp_if.source  rsp,
   mpbm_csr_if.sink    csr
);
   import mpbm_pkg::*;

   // Configuration registers
   pattern_type [HW_SLOTS-1:0] pattern_ff;
   logic [4*HW_SLOTS-1:0]      lengths_ff;
   logic [2:0]                 slots_ff;
   logic [TICK_W-1:0]          timeout_ff;

   // Input stage
   logic                s1_valid_ff, s1_valid_in;
   logic [ACTION_W-1:0] s1_action_ff;
   logic [BYTE_W-1:0]   s1_byte_ff;

   // Search state
   pos_type [NUM_SLOTS-1:0] pos_ff, pos_in;
   logic [TICK_W-1:0]       elapsed_ff, elapsed_in;
   logic [STATUS_W-1:0]     status_ff, status_in;
   logic [SLOT_ID_W-1:0]    found_ff, found_in;

   // Result stage
   logic                 out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0]  out_status_ff;
   logic [SLOT_ID_W-1:0] out_slot_ff;

   logic advance;
   logic fire_in;
   logic step;
   logic start_step;

   // Handshake: the input stage moves on whenever the result register frees
   assign advance      = !out_valid_ff || rsp.ready;
   assign req.ready    = !s1_valid_ff || advance;
   assign fire_in      = req.valid && req.ready;
   assign step         = s1_valid_ff && advance;
   assign start_step   = step && (s1_action_ff == ACT_START);
   assign s1_valid_in  = fire_in || (s1_valid_ff && !advance);
   assign out_valid_in = step || (out_valid_ff && !rsp.ready);
   assign csr.ready    = 1'b1;

   assign rsp.valid        = out_valid_ff;
   assign rsp.status       = out_status_ff;
   assign rsp.matched_slot = out_slot_ff;

   // Next state: start clears, ticks count to timeout, bytes match active slots, lowest wins
   always_comb begin
      logic [3:0]              len;
      logic [3:0]              active;
      logic [BYTE_W-1:0]       expect_byte;
      logic                    hit;
      logic                    blocked;
      logic [POS_W-1:0]        pos_next;
      logic [TICK_W-1:0]       elapsed_inc;

      pos_in      = pos_ff;
      elapsed_in  = elapsed_ff;
      status_in   = status_ff;
      found_in    = found_ff;
      blocked     = 1'b0;
      len         = '0;
      expect_byte = '0;
      hit         = 1'b0;
      pos_next    = '0;
      active      = (4'(slots_ff) > 4'(NUM_SLOTS)) ? 4'(NUM_SLOTS) : 4'(slots_ff);
      elapsed_inc = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + TICK_W'(1);

      if (step) begin
         case (s1_action_ff)
            ACT_START: begin
               pos_in     = '0;
               elapsed_in = '0;
               status_in  = ST_SEARCHING;
               found_in   = '0;
            end
            ACT_BYTE: begin
               if (status_ff == ST_SEARCHING) begin
                  for (int s = 0; s < NUM_SLOTS; s++) begin
                     len = lengths_ff[4*s +: 4];
                     if (len > 4'(MAX_PATTERN_BYTES)) begin
                        len = 4'(MAX_PATTERN_BYTES);
                     end
                     expect_byte = pattern_ff[s][pos_ff[s][2:0]];
                     hit         = (pos_ff[s] < len) && (s1_byte_ff == expect_byte);
                     pos_next    = pos_ff[s] + POS_W'(1);
                     if (!blocked && (4'(s) < active) && (len != 4'd0)) begin
                        if (hit) begin
                           pos_in[s] = pos_next;
                           if (pos_next == len) begin
                              status_in = ST_FOUND;
                              found_in  = SLOT_ID_W'(s + 1);
                              blocked   = 1'b1;
                           end
                        end else begin
                           pos_in[s] = (s1_byte_ff == pattern_ff[s][0]) ? 4'd1 : 4'd0;
                        end
                     end
                  end
               end
            end
            ACT_TICK: begin
               if (status_ff == ST_SEARCHING) begin
                  elapsed_in = elapsed_inc;
                  if (elapsed_inc >= timeout_ff) begin
                     status_in = ST_TIMEOUT;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Hold configuration, stage input, advance state and result
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff   <= '0;
         lengths_ff   <= '0;
         slots_ff     <= SLOTS_RESET;
         timeout_ff   <= TIMEOUT_RESET;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pos_ff       <= '0;
         elapsed_ff   <= '0;
         status_ff    <= ST_SEARCHING;
         found_ff     <= '0;
      end else begin
         if (csr.valid) begin
            case (csr.index)
               REG_PATTERN_A:   pattern_ff[0] <= csr.data;
               REG_PATTERN_B:   pattern_ff[1] <= csr.data;
               REG_PATTERN_C:   pattern_ff[2] <= csr.data;
               REG_PATTERN_D:   pattern_ff[3] <= csr.data;
               REG_LENGTHS:     lengths_ff    <= csr.data[4*HW_SLOTS-1:0];
               REG_SLOTS_INUSE: slots_ff      <= csr.data[2:0];
               REG_TIMEOUT:     timeout_ff    <= csr.data[TICK_W-1:0];
               default: begin
               end
            endcase
         end
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         pos_ff       <= pos_in;
         elapsed_ff   <= elapsed_in;
         status_ff    <= status_in;
         found_ff     <= found_in;
      end
   end

   // Payload registers need no reset
   always_ff @(posedge clock) begin
      if (fire_in) begin
         s1_action_ff <= req.action;
         s1_byte_ff   <= req.rx_byte;
      end
      if (step) begin
         out_status_ff <= status_in;
         out_slot_ff   <= (status_in == ST_FOUND) ? found_in : '0;
      end
   end

   // Checks on the result word and the held search state
   `MPBM_ASSERT_NOW(a_found_has_slot, rsp.valid && (rsp.status == ST_FOUND), rsp.matched_slot != '0)
   `MPBM_ASSERT_NOW(a_slot_only_when_found, rsp.valid && (rsp.status != ST_FOUND), rsp.matched_slot == '0)
   `MPBM_ASSERT_NEXT(a_final_status_held, (status_ff != ST_SEARCHING) && !start_step, $stable(status_ff) && $stable(found_ff))
   `MPBM_ASSERT_NEXT(a_start_clears, start_step, (elapsed_ff == '0) && (status_ff == ST_SEARCHING))

endmodule

[bench/multi_pattern_byte_matcher_test.sv]
// Self-checking bench for the multi-pattern byte matcher: directed cases then random sessions.
`timescale 1ns / 100ps

module multi_pattern_byte_matcher_test;
   import mpbm_pkg::*;

   // Action code with no meaning to the block
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
   localparam int QUIET_LIMIT = 1000;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [SLOT_ID_W-1:0] matched_slot;
   } search_report_type;

   logic clock;
   logic reset;

   mpbm_req_if req_if ();
   mpbm_rsp_if rsp_if ();
   mpbm_csr_if csr_if ();

   multi_pattern_byte_matcher dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if),
      .csr   (csr_if)
   );

   // Mirror of the block's registers and search state
   pattern_type       pat_reg [HW_SLOTS];
   logic [15:0]       len_reg;
   logic [2:0]        slots_reg;
   logic [TICK_W-1:0] timeout_reg;
   pos_type           pos_q [HW_SLOTS];
   logic [TICK_W-1:0] ticks_q;
   logic [STATUS_W-1:0]  status_q;
   logic [SLOT_ID_W-1:0] found_q;

   search_report_type status_due [$];
   search_report_type report_want;
   int             fail_count = 0;
   int             burst_left;
   int             words_sent;
   int             rsp_hold = 0;
   int             quiet_cycles = 0;
   logic [31:0]    cycle_count = '0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int slot_len(int s);
      int n;
      n = int'(len_reg[4*s +: 4]);
      if (n > MAX_PATTERN_BYTES)
         n = MAX_PATTERN_BYTES;
      return n;
   endfunction

   function automatic void clear_search();
      for (int i = 0; i < HW_SLOTS; i++)
         pos_q[i] = '0;
      ticks_q  = '0;
      status_q = ST_SEARCHING;
      found_q  = '0;
   endfunction

   function automatic void apply_register(logic [CSR_IDX_W-1:0] idx,
                                          logic [CSR_DATA_W-1:0] data);
      case (idx)
         REG_PATTERN_A:   pat_reg[0] = data;
         REG_PATTERN_B:   pat_reg[1] = data;
         REG_PATTERN_C:   pat_reg[2] = data;
         REG_PATTERN_D:   pat_reg[3] = data;
         REG_LENGTHS:     len_reg = data[15:0];
         REG_SLOTS_INUSE: slots_reg = data[2:0];
         REG_TIMEOUT:     timeout_reg = data[TICK_W-1:0];
         default: ;
      endcase
   endfunction

   // Step the search by one word and return the report it produces
   function automatic search_report_type advance_search(logic [ACTION_W-1:0] act,
                                                        logic [BYTE_W-1:0] b);
      search_report_type r;
      int  active;
      int  len;
      bit  done;
      done   = 1'b0;
      active = (int'(slots_reg) > NUM_SLOTS) ? NUM_SLOTS : int'(slots_reg);
      if (act == ACT_START) begin
         clear_search();
      end else if (act == ACT_BYTE && status_q == ST_SEARCHING) begin
         for (int s = 0; s < NUM_SLOTS; s++) begin
            len = slot_len(s);
            if (s < active && !done && len != 0) begin
               if (int'(pos_q[s]) < len && b == pat_reg[s][pos_q[s][2:0]]) begin
                  pos_q[s] = pos_q[s] + POS_W'(1);
                  if (int'(pos_q[s]) == len) begin
                     status_q = ST_FOUND;
                     found_q  = SLOT_ID_W'(s + 1);
                     done     = 1'b1;
                  end
               end else begin
                  // simplified restart: only the first character is retried
                  pos_q[s] = (b == pat_reg[s][0]) ? 4'd1 : 4'd0;
               end
            end
         end
      end else if (act == ACT_TICK && status_q == ST_SEARCHING) begin
         if (ticks_q != 16'hFFFF)
            ticks_q = ticks_q + TICK_W'(1);
         if (ticks_q >= timeout_reg)
            status_q = ST_TIMEOUT;
      end
      r.status       = status_q;
      r.matched_slot = (status_q == ST_FOUND) ? found_q : '0;
      return r;
   endfunction

   // Predict on accepted words, check accepted results against the oldest report
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_if.valid && csr_if.ready)
            apply_register(csr_if.index, csr_if.data);
         if (req_if.valid && req_if.ready)
            status_due.push_back(advance_search(req_if.action, req_if.rx_byte));
         if (rsp_if.valid && rsp_if.ready) begin
            if (status_due.size() == 0) begin
               $error("result word with no report outstanding: status %0d slot %0d",
                      rsp_if.status, rsp_if.matched_slot);
               fail_count++;
            end else begin
               report_want = status_due.pop_front();
               if (rsp_if.status !== report_want.status) begin
                  $error("status: expected %0d, got %0d", report_want.status, rsp_if.status);
                  fail_count++;
               end
               if (rsp_if.matched_slot !== report_want.matched_slot) begin
                  $error("matched_slot: expected %0d, got %0d",
                         report_want.matched_slot, rsp_if.matched_slot);
                  fail_count++;
               end
            end
         end
      end
   end

   // Receiver: stall-free stretches alternate with random stalls, switched by bit 8 of the cycle counter
   always @(posedge clock) begin
      cycle_count = cycle_count + 32'd1;
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
         if (cycle_count[8] && $urandom_range(0, 5) == 0)
            rsp_hold = $urandom_range(1, 12);
      end
   end

   // Watchdog: give up when no channel has moved a word for too long
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Send one word, opening a gap first when the current burst is spent
   task automatic send_word(input logic [ACTION_W-1:0] act, input logic [BYTE_W-1:0] b);
      int gap;
      if (burst_left == 0) begin
         gap        = $urandom_range(1, 5);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 100)
                                                  : $urandom_range(1, 8);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      burst_left--;
      req_if.valid   <= 1'b1;
      req_if.action  <= act;
      req_if.rx_byte <= b;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      words_sent++;
   endtask

   // Drop valid and hold until every report has come back
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (status_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Reset values: slot 0 disabled, so nothing matches and one tick does not expire
   task automatic test_reset_defaults();
      send_word(ACT_START, 8'h00);
      send_word(ACT_BYTE, 8'hFF);
      send_word(ACT_TICK, 8'h00);
      send_word(ACT_UNUSED, 8'hA5);
      wait_idle();
   endtask

   // Lowest slot wins a tie; clamped length, disabled slot, saturated slot count, zero timeout
   task automatic test_priority_and_timeout();
      write_reg(REG_PATTERN_A, 64'h4B4F);
      write_reg(REG_PATTERN_B, 64'h4B);
      write_reg(REG_PATTERN_C, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(REG_PATTERN_D, 64'h0);
      write_reg(REG_LENGTHS, 64'h0F12);
      write_reg(REG_SLOTS_INUSE, 64'd7);
      write_reg(REG_TIMEOUT, 64'd0);
      send_word(ACT_START, 8'h00);
      send_word(ACT_BYTE, 8'h4F);
      send_word(ACT_BYTE, 8'h4B);
      send_word(ACT_BYTE, 8'h4B);
      send_word(ACT_TICK, 8'h00);
      send_word(ACT_START, 8'h00);
      send_word(ACT_TICK, 8'h00);
      send_word(ACT_BYTE, 8'hFF);
      wait_idle();
   endtask

   // Restart only retries the first character, so an overlapping prefix is lost
   task automatic test_restart_rule();
      write_reg(REG_PATTERN_A, 64'h42_4141);
      write_reg(REG_LENGTHS, 64'h0003);
      write_reg(REG_SLOTS_INUSE, 64'd1);
      write_reg(REG_TIMEOUT, 64'hFFFF);
      send_word(ACT_START, 8'h00);
      send_word(ACT_BYTE, 8'h41);
      send_word(ACT_BYTE, 8'h41);
      send_word(ACT_BYTE, 8'h41);
      send_word(ACT_BYTE, 8'h42);
      send_word(ACT_BYTE, 8'h41);
      send_word(ACT_BYTE, 8'h41);
      send_word(ACT_BYTE, 8'h42);
      send_word(ACT_TICK, 8'h00);
      wait_idle();
   endtask

   // Shorten a length below the match position mid-search, then turn all slots off
   task automatic test_live_reconfig();
      send_word(ACT_START, 8'h00);
      send_word(ACT_BYTE, 8'h41);
      send_word(ACT_BYTE, 8'h41);
      wait_idle();
      write_reg(REG_LENGTHS, 64'h0001);
      send_word(ACT_BYTE, 8'h41);
      send_word(ACT_BYTE, 8'h41);
      wait_idle();
      write_reg(REG_SLOTS_INUSE, 64'd0);
      send_word(ACT_BYTE, 8'h41);
      wait_idle();
   endtask

   function automatic logic [7:0] alphabet_char();
      case ($urandom_range(0, 3))
         0: return 8'h41;
         1: return 8'h42;
         2: return 8'h43;
         default: return 8'h0D;
      endcase
   endfunction

   // Mostly characters the patterns use, sometimes any byte
   function automatic logic [7:0] pick_char();
      if ($urandom_range(0, 3) == 0)
         return 8'($urandom_range(0, 255));
      return pat_reg[$urandom_range(0, 3)][$urandom_range(0, 7)];
   endfunction

   task automatic random_config(input int phase);
      pattern_type p;
      logic [15:0] lens;
      int          r;
      for (int s = 0; s < HW_SLOTS; s++) begin
         if ($urandom_range(0, 5) == 0)
            p = {$urandom, $urandom};
         else
            for (int k = 0; k < MAX_PATTERN_BYTES; k++)
               p[k] = alphabet_char();
         case (s)
            0: write_reg(REG_PATTERN_A, p);
            1: write_reg(REG_PATTERN_B, p);
            2: write_reg(REG_PATTERN_C, p);
            default: write_reg(REG_PATTERN_D, p);
         endcase
      end
      for (int s = 0; s < 4; s++) begin
         r = $urandom_range(0, 9);
         lens[4*s +: 4] = (r == 9) ? 4'($urandom_range(9, 15)) : 4'(r);
      end
      if (phase == 0)
         lens = 16'hFFFF;
      write_reg(REG_LENGTHS, 64'(lens));
      write_reg(REG_SLOTS_INUSE,
                ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 7)) : 64'd4);
      case ($urandom_range(0, 7))
         0: write_reg(REG_TIMEOUT, 64'd0);
         1: write_reg(REG_TIMEOUT, 64'd1);
         2: write_reg(REG_TIMEOUT, 64'hFFFF);
         default: write_reg(REG_TIMEOUT, 64'($urandom_range(2, 60)));
      endcase
   endtask

   // Sessions: start, some noise, one slot's pattern (sometimes broken), a tail
   task automatic test_random_traffic(input int phase, input int word_count);
      int first_word;
      int slot;
      int len;
      bit broken;
      random_config(phase);
      first_word = words_sent;
      while (words_sent - first_word < word_count) begin
         send_word(ACT_START, 8'($urandom_range(0, 255)));
         repeat ($urandom_range(0, 3)) send_word(ACT_BYTE, pick_char());
         slot   = $urandom_range(0, 3);
         len    = (slot_len(slot) != 0) ? slot_len(slot) : int'($urandom_range(1, 8));
         broken = ($urandom_range(0, 4) == 0);
         for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 5) == 0)
               send_word(ACT_TICK, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 39) == 0)
               send_word(ACT_UNUSED, 8'($urandom_range(0, 255)));
            if (broken && k == len - 1)
               send_word(ACT_BYTE, pick_char());
            else
               send_word(ACT_BYTE, pat_reg[slot][k]);
         end
         repeat ($urandom_range(0, 3))
            send_word(($urandom_range(0, 1) == 0) ? ACT_TICK : ACT_BYTE, pick_char());
      end
      wait_idle();
   endtask

   initial begin
      burst_left   = 0;
      words_sent   = 0;
      for (int i = 0; i < HW_SLOTS; i++)
         pat_reg[i] = '0;
      len_reg     = '0;
      slots_reg   = SLOTS_RESET;
      timeout_reg = TIMEOUT_RESET;
      clear_search();
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.action  <= ACT_START;
      req_if.rx_byte <= '0;
      csr_if.valid   <= 1'b0;
      csr_if.index   <= REG_PATTERN_A;
      csr_if.data    <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_priority_and_timeout();
      test_restart_rule();
      test_live_reconfig();
      for (int phase = 0; phase < 8; phase++)
         test_random_traffic(phase, 200);

      wait_idle();
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
